>>> rtl/assert_macros.svh
// Shared assertion macros for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, including the reset cycles.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

// Checked at every rising edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

`endif

>>> rtl/fiac_pkg.sv
`timescale 1ns / 1ps

package fiac_pkg;

   localparam int ADDR_WIDTH  = 14;
   localparam int DATA_WIDTH  = 16;
   localparam int START_RESET = 1024;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_READ    = 2'd1,
      KIND_EXEC    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_STORE = 2'd1,
      OP_SUB   = 2'd2,
      OP_JUMP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_OPERAND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [ADDR_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic [ADDR_WIDTH-1:0] program_counter;
      logic [DATA_WIDTH-1:0] accumulator;
      logic                  borrow;
   } rsp_payload_type;

endpackage

>>> rtl/four_instruction_accumulator_cpu_top.sv
`timescale 1ns / 1ps
// After accept: write, restart go to ST_FINISH; read via ST_READ; execute via ST_FETCH (store,
// jump) or ST_FETCH, ST_OPERAND (load, subtract), then ST_FINISH; one item in work at a time,
// next item taken in ST_IDLE; steps set by the single memory port (fetch, then operand access).
// A result waits in the output register; the next item is taken meanwhile.
// Reset (synchronous): a clearing pass writes zero to all MEM_WORDS words, one per cycle,
// while req_ready stays low; csr writes are taken once reset is released.

module four_instruction_accumulator_cpu_top #(
   parameter int MEM_WORDS = 16384
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fiac_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fiac_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fiac_pkg::ADDR_WIDTH-1:0]     csr_data
);

   localparam int AW = $clog2(MEM_WORDS);
   // remainder work width: quotient of a 14-bit address is at most 15
   localparam int RW = fiac_pkg::ADDR_WIDTH + 4;
   localparam logic [AW-1:0] PC_RESET  = AW'(fiac_pkg::START_RESET % MEM_WORDS);
   localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

   // Address modulo MEM_WORDS by four restoring subtract steps (8x, 4x, 2x, 1x).
   function automatic logic [AW-1:0] wrap_addr(input logic [fiac_pkg::ADDR_WIDTH-1:0] a);
      logic [RW-1:0] r;
      r = RW'(a);
      for (int k = 3; k >= 0; k--) begin
         if (r >= RW'(MEM_WORDS << k)) begin
            r = r - RW'(MEM_WORDS << k);
         end
      end
      return r[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] next_pc(input logic [AW-1:0] pc);
      return (pc == LAST_WORD) ? '0 : pc + AW'(1);
   endfunction

   // control state
   fiac_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clear_ff, clear_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // architectural registers
   logic [AW-1:0]                     pc_ff, pc_in;
   logic [fiac_pkg::DATA_WIDTH-1:0]   acc_ff, acc_in;
   logic                              borrow_ff, borrow_in;
   logic [fiac_pkg::ADDR_WIDTH-1:0]   start_ff, start_in;

   // payload holding
   fiac_pkg::opcode_type              op_ff, op_in;
   logic [fiac_pkg::DATA_WIDTH-1:0]   rdval_ff, rdval_in;
   fiac_pkg::rsp_payload_type         rsp_data_ff, rsp_data_in;

   // memory port
   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic [fiac_pkg::DATA_WIDTH-1:0]   ram_wdata;
   logic [AW-1:0]                     ram_raddr;
   logic [fiac_pkg::DATA_WIDTH-1:0]   ram_rdata;

   // instruction decode straight off the read port (valid in ST_FETCH)
   fiac_pkg::opcode_type              fetch_op;
   logic [AW-1:0]                     fetch_ea;
   logic [fiac_pkg::DATA_WIDTH:0]     diff;

   fiac_ram #(
      .WIDTH (fiac_pkg::DATA_WIDTH),
      .DEPTH (MEM_WORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign fetch_op = fiac_pkg::opcode_type'(ram_rdata[15:14]);
   assign fetch_ea = wrap_addr(ram_rdata[fiac_pkg::ADDR_WIDTH-1:0]);
   // 17-bit difference: bit 16 is the borrow
   assign diff     = {1'b0, ram_rdata} - {1'b0, acc_ff};

   // start address register: writable outside reset, used at the next restart
   assign csr_ready = !reset;
   assign start_in  = csr_valid ? csr_data : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fiac_pkg::ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= PC_RESET;
         acc_ff       <= '0;
         borrow_ff    <= 1'b0;
         start_ff     <= fiac_pkg::ADDR_WIDTH'(fiac_pkg::START_RESET);
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         borrow_ff    <= borrow_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rdval_ff    <= rdval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      borrow_in    = borrow_ff;
      op_in        = op_ff;
      rdval_in     = rdval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = clear_ff;
      ram_wdata    = '0;
      ram_raddr    = wrap_addr(req_data.address);

      unique case (state_ff)
         fiac_pkg::ST_CLEAR: begin
            // zero one word per cycle after reset
            ram_we = 1'b1;
            if (clear_ff == LAST_WORD) begin
               state_in = fiac_pkg::ST_IDLE;
            end else begin
               clear_in = clear_ff + AW'(1);
            end
         end
         fiac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rdval_in = '0;
               unique case (req_data.kind)
                  fiac_pkg::KIND_WRITE: begin
                     ram_we    = 1'b1;
                     ram_waddr = wrap_addr(req_data.address);
                     ram_wdata = req_data.write_data;
                     state_in  = fiac_pkg::ST_FINISH;
                  end
                  fiac_pkg::KIND_READ: begin
                     // read address already on the port
                     state_in = fiac_pkg::ST_READ;
                  end
                  fiac_pkg::KIND_EXEC: begin
                     ram_raddr = pc_ff;
                     state_in  = fiac_pkg::ST_FETCH;
                  end
                  fiac_pkg::KIND_RESTART: begin
                     pc_in     = wrap_addr(start_ff);
                     acc_in    = '0;
                     borrow_in = 1'b0;
                     state_in  = fiac_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         fiac_pkg::ST_READ: begin
            rdval_in = ram_rdata;
            state_in = fiac_pkg::ST_FINISH;
         end
         fiac_pkg::ST_FETCH: begin
            op_in = fetch_op;
            unique case (fetch_op)
               fiac_pkg::OP_LOAD, fiac_pkg::OP_SUB: begin
                  ram_raddr = fetch_ea;
                  state_in  = fiac_pkg::ST_OPERAND;
               end
               fiac_pkg::OP_STORE: begin
                  // written here, seen by any later fetch or operand read
                  ram_we    = 1'b1;
                  ram_waddr = fetch_ea;
                  ram_wdata = acc_ff;
                  pc_in     = next_pc(pc_ff);
                  state_in  = fiac_pkg::ST_FINISH;
               end
               fiac_pkg::OP_JUMP: begin
                  pc_in    = borrow_ff ? next_pc(pc_ff) : fetch_ea;
                  state_in = fiac_pkg::ST_FINISH;
               end
            endcase
         end
         fiac_pkg::ST_OPERAND: begin
            if (op_ff == fiac_pkg::OP_SUB) begin
               acc_in    = diff[fiac_pkg::DATA_WIDTH-1:0];
               borrow_in = diff[fiac_pkg::DATA_WIDTH];
            end else begin
               acc_in = ram_rdata;
            end
            pc_in    = next_pc(pc_ff);
            state_in = fiac_pkg::ST_FINISH;
         end
         fiac_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.read_data       = rdval_ff;
               rsp_data_in.program_counter = fiac_pkg::ADDR_WIDTH'(pc_ff);
               rsp_data_in.accumulator     = acc_ff;
               rsp_data_in.borrow          = borrow_ff;
               state_in                    = fiac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fiac_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/fiac_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module fiac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fiac_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fiac_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input fiac_pkg::rsp_payload_type rsp_data
);

   // memory clear runs right after reset, no transfer taken
   `ASSERT_ALWAYS(a_clear_after_reset, clock, $past(reset) |-> !req_ready)

   // one item in work at a time
   `ASSERT_SYNC(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

   `ASSERT_SYNC(a_rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   `ASSERT_SYNC(a_rsp_hold_data, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data))

endmodule

bind four_instruction_accumulator_cpu_top fiac_checker u_checker (.*);
